// ----- rtl/core/obj_corner_vertex_dedup_unit_macros.svh -----
// assertion macros for the corner de-duplication block and its checker
// clocked on i_clk; the reset-gated forms use i_rst_n (active low)
`ifndef OBJ_CORNER_VERTEX_DEDUP_UNIT_MACROS_SVH
`define OBJ_CORNER_VERTEX_DEDUP_UNIT_MACROS_SVH

// same-cycle implication, ignored while reset is low
`define OCVD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, ignored while reset is low
`define OCVD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also holds across reset
`define OCVD_ASSERT_ALWAYS(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/ocvd_pkg.sv -----
// shared types, constants and the key hash for the corner de-duplication block
// no dependencies
package ocvd_pkg;

    localparam int REF_W          = 18;
    localparam int CNT_W          = 17;
    localparam int IDX_W          = 17;
    localparam int POS_IDX_W      = 16;
    localparam int VNUM_W         = 12;
    localparam int KEY_W          = 3 * IDX_W;

    localparam int DEF_MAX_VERTICES = 4096;
    localparam int MAX_ATTRIBUTES   = 65536;
    localparam int INDEX_LIMIT      = 65536;
    localparam int ATTR_LIMIT       = (MAX_ATTRIBUTES < INDEX_LIMIT) ?
                                      MAX_ATTRIBUTES : INDEX_LIMIT;

    // resolved reference meaning "use the default value"
    localparam logic [IDX_W-1:0] IDX_NONE = '1;

    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_SKIP = 2'd1,
        STATUS_FULL = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RES_P,
        ST_RES_T,
        ST_RES_N,
        ST_READ,
        ST_CMP,
        ST_DONE
    } t_state;

    // result of one reference resolution
    typedef struct packed {
        logic             ok;
        logic [IDX_W-1:0] idx;
    } t_res;

    // xor fold of the three key fields, rotated so sequential refs spread
    function automatic logic [IDX_W-1:0] key_hash(logic [KEY_W-1:0] key);
        logic [IDX_W-1:0] p;
        logic [IDX_W-1:0] t;
        logic [IDX_W-1:0] n;
        begin
            p = key[3*IDX_W-1 -: IDX_W];
            t = key[2*IDX_W-1 -: IDX_W];
            n = key[IDX_W-1:0];
            key_hash = p ^ {t[7:0], t[16:8]} ^ {n[12:0], n[16:13]};
        end
    endfunction

endpackage

// ----- rtl/core/ocvd_resolve.sv -----
// shared reference resolver: one add and one range compare
// depends on ocvd_pkg
module ocvd_resolve
    import ocvd_pkg::*;
(
    input  logic signed [REF_W-1:0] i_ref,
    input  logic        [CNT_W-1:0] i_count,
    output t_res                    o_res
);

    logic [CNT_W-1:0]      size;
    logic signed [REF_W:0] ref_x;
    logic signed [REF_W:0] addend;
    logic signed [REF_W:0] sum;
    logic                  ref_pos;
    logic                  ref_neg;
    logic                  in_range;

    always_comb begin
        // count clipped to what an index field can address
        if (i_count > CNT_W'(ATTR_LIMIT)) begin
            size = CNT_W'(ATTR_LIMIT);
        end else begin
            size = i_count;
        end
        ref_x   = {i_ref[REF_W-1], i_ref};
        ref_neg = i_ref[REF_W-1];
        ref_pos = !ref_neg && (i_ref != '0);
        // positive: ref - 1, negative: size + ref
        addend  = ref_pos ? '1 : $signed({2'b00, size});
        sum     = addend + ref_x;
        if (ref_pos) begin
            in_range = (sum[REF_W-1:0] < {1'b0, size});
        end else if (ref_neg) begin
            in_range = !sum[REF_W];
        end else begin
            in_range = 1'b0;
        end
        o_res.ok  = in_range;
        o_res.idx = in_range ? sum[IDX_W-1:0] : IDX_NONE;
    end

endmodule

// ----- rtl/core/ocvd_table.sv -----
// hash table storage: one write port, one registered read port
// depends on ocvd_pkg for default widths
module ocvd_table
    import ocvd_pkg::*;
#(
    parameter int ADDR_W = $clog2(DEF_MAX_VERTICES) + 1,
    parameter int DATA_W = 1 + KEY_W + $clog2(DEF_MAX_VERTICES)
) (
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data
);

    localparam int DEPTH = 2 ** ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/core/obj_corner_vertex_dedup_unit.sv -----
// corner de-duplication top level over ocvd_pkg: resolver, linear-probe hash table, sequencer
// steps: ST_RES_P, ST_RES_T, ST_RES_N, then ST_READ and ST_CMP per probe, then ST_DONE; a skipped
// corner goes from ST_RES_N to ST_DONE; a stalled result word holds the sequencer in ST_DONE
// a new word is taken only in ST_IDLE, so never while a corner is in progress; the next
// word is taken the cycle after the previous result is loaded into the output register
// reset: synchronous; then a sweep empties 2**(clog2(MAX_VERTICES)+1) slots (8192), stall high
module obj_corner_vertex_dedup_unit
    import ocvd_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input word channel
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic signed [REF_W-1:0]     i_pos_ref,
    input  logic signed [REF_W-1:0]     i_tex_ref,
    input  logic signed [REF_W-1:0]     i_norm_ref,
    input  logic        [CNT_W-1:0]     i_pos_count,
    input  logic        [CNT_W-1:0]     i_tex_count,
    input  logic        [CNT_W-1:0]     i_norm_count,
    // result word channel
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic        [1:0]           o_status,
    output logic        [VNUM_W-1:0]    o_vertex_number,
    output logic                        o_is_new,
    output logic        [POS_IDX_W-1:0] o_pos_index,
    output logic signed [IDX_W-1:0]     o_tex_index,
    output logic signed [IDX_W-1:0]     o_norm_index
);

    // vertex number width, table address width (table is at least twice the
    // vertex limit so a probe run always meets an empty slot) and entry width
    localparam int NW = $clog2(MAX_VERTICES);
    localparam int HW = NW + 1;
    localparam int EW = 1 + KEY_W + NW;

    t_state r_state, n_state;

    // latched input word
    logic signed [REF_W-1:0] r_pos_ref, r_tex_ref, r_norm_ref;
    logic        [CNT_W-1:0] r_pos_count, r_tex_count, r_norm_count;

    // resolved references
    t_res r_p, r_t, r_n;
    t_res res;
    logic signed [REF_W-1:0] res_ref;
    logic        [CNT_W-1:0] res_cnt;

    // probe and fill state
    logic [HW-1:0] r_idx;
    logic [HW-1:0] r_clr;
    logic [NW:0]   r_next;

    // staged result
    t_status       r_res_status;
    logic [NW-1:0] r_res_num;
    logic          r_res_new;

    // output register
    logic                 r_ovalid;
    t_status              r_o_status;
    logic [VNUM_W-1:0]    r_o_vnum;
    logic                 r_o_new;
    logic [POS_IDX_W-1:0] r_o_pos;
    logic [IDX_W-1:0]     r_o_tex;
    logic [IDX_W-1:0]     r_o_norm;

    // table port
    logic          tbl_rd_en;
    logic [EW-1:0] tbl_rd_data;
    logic          tbl_wr_en;
    logic [HW-1:0] tbl_wr_addr;
    logic [EW-1:0] tbl_wr_data;

    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] key_early;
    logic             ent_valid;
    logic [KEY_W-1:0] ent_key;
    logic [NW-1:0]    ent_num;
    logic             hit;
    logic             miss;
    logic             full;
    logic             in_acc;
    logic             out_free;
    logic [31:0]      num_ext;
    logic [IDX_W-1:0] hash_early;

    // shared resolver, fed one reference per cycle
    ocvd_resolve u_resolve (
        .i_ref   (res_ref),
        .i_count (res_cnt),
        .o_res   (res)
    );

    ocvd_table #(
        .ADDR_W (HW),
        .DATA_W (EW)
    ) u_table (
        .i_clk     (i_clk),
        .i_rd_en   (tbl_rd_en),
        .i_rd_addr (r_idx),
        .o_rd_data (tbl_rd_data),
        .i_wr_en   (tbl_wr_en),
        .i_wr_addr (tbl_wr_addr),
        .i_wr_data (tbl_wr_data)
    );

    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_ovalid || !i_stall;

    // key as stored: {pos, tex, norm}, defaulted refs carry all ones
    assign key       = {r_p.idx, r_t.idx, r_n.idx};
    assign key_early = {r_p.idx, r_t.idx, res.idx};
    assign hash_early = key_hash(key_early);

    assign ent_valid = tbl_rd_data[EW-1];
    assign ent_key   = tbl_rd_data[EW-2 -: KEY_W];
    assign ent_num   = tbl_rd_data[NW-1:0];
    assign hit       = ent_valid && (ent_key == key);
    assign miss      = !ent_valid;
    assign full      = (r_next >= (NW+1)'(MAX_VERTICES));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr == '1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = ST_RES_P;
                end
            end
            ST_RES_P: n_state = ST_RES_T;
            ST_RES_T: n_state = ST_RES_N;
            ST_RES_N: begin
                // invalid position skips the lookup entirely
                n_state = r_p.ok ? ST_READ : ST_DONE;
            end
            ST_READ: n_state = ST_CMP;
            ST_CMP: begin
                if (hit || miss) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_READ;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath controls
    always_comb begin
        o_stall     = (r_state != ST_IDLE);
        tbl_rd_en   = (r_state == ST_READ);
        tbl_wr_en   = 1'b0;
        tbl_wr_addr = r_idx;
        tbl_wr_data = {1'b1, key, r_next[NW-1:0]};
        res_ref     = r_pos_ref;
        res_cnt     = r_pos_count;
        case (r_state)
            ST_CLEAR: begin
                // sweep writes empty entries
                tbl_wr_en   = 1'b1;
                tbl_wr_addr = r_clr;
                tbl_wr_data = '0;
            end
            ST_RES_T: begin
                res_ref = r_tex_ref;
                res_cnt = r_tex_count;
            end
            ST_RES_N: begin
                res_ref = r_norm_ref;
                res_cnt = r_norm_count;
            end
            ST_CMP: begin
                tbl_wr_en = miss && !full;
            end
            default: begin
                tbl_wr_en = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_next   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (r_state == ST_CMP && miss && !full) begin
                r_next <= r_next + 1'b1;
            end
            if (r_state == ST_DONE && out_free) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_pos_ref    <= i_pos_ref;
            r_tex_ref    <= i_tex_ref;
            r_norm_ref   <= i_norm_ref;
            r_pos_count  <= i_pos_count;
            r_tex_count  <= i_tex_count;
            r_norm_count <= i_norm_count;
        end
        case (r_state)
            ST_RES_P: r_p <= res;
            ST_RES_T: r_t <= res;
            ST_RES_N: begin
                r_n          <= res;
                // home slot of the probe run
                r_idx        <= HW'(hash_early ^ (hash_early >> HW));
                r_res_status <= STATUS_SKIP;
                r_res_num    <= '0;
                r_res_new    <= 1'b0;
            end
            ST_CMP: begin
                if (hit) begin
                    r_res_status <= STATUS_OK;
                    r_res_num    <= ent_num;
                    r_res_new    <= 1'b0;
                end else if (miss && full) begin
                    r_res_status <= STATUS_FULL;
                    r_res_num    <= '0;
                    r_res_new    <= 1'b0;
                end else if (miss) begin
                    r_res_status <= STATUS_OK;
                    r_res_num    <= r_next[NW-1:0];
                    r_res_new    <= 1'b1;
                end else begin
                    // occupied by another key, linear probe
                    r_idx <= r_idx + 1'b1;
                end
            end
            default: begin
                r_idx <= r_idx;
            end
        endcase
        if (r_state == ST_DONE && out_free) begin
            r_o_status <= r_res_status;
            r_o_vnum   <= num_ext[VNUM_W-1:0];
            r_o_new    <= r_res_new;
            if (r_res_status == STATUS_SKIP) begin
                r_o_pos  <= '0;
                r_o_tex  <= '0;
                r_o_norm <= '0;
            end else begin
                r_o_pos  <= r_p.idx[POS_IDX_W-1:0];
                r_o_tex  <= r_t.idx;
                r_o_norm <= r_n.idx;
            end
        end
    end

    assign num_ext = 32'(r_res_num);

    assign o_valid         = r_ovalid;
    assign o_status        = r_o_status;
    assign o_vertex_number = r_o_vnum;
    assign o_is_new        = r_o_new;
    assign o_pos_index     = r_o_pos;
    assign o_tex_index     = $signed(r_o_tex);
    assign o_norm_index    = $signed(r_o_norm);

endmodule

// ----- rtl/core/ocvd_checker.sv -----
// port-level checker for the corner de-duplication block, bound to the top level
// depends on ocvd_pkg and obj_corner_vertex_dedup_unit_macros.svh
`include "obj_corner_vertex_dedup_unit_macros.svh"

module ocvd_checker
    import ocvd_pkg::*;
(
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        o_stall,
    input logic signed [REF_W-1:0]     i_pos_ref,
    input logic signed [REF_W-1:0]     i_tex_ref,
    input logic signed [REF_W-1:0]     i_norm_ref,
    input logic        [CNT_W-1:0]     i_pos_count,
    input logic        [CNT_W-1:0]     i_tex_count,
    input logic        [CNT_W-1:0]     i_norm_count,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic        [1:0]           o_status,
    input logic        [VNUM_W-1:0]    o_vertex_number,
    input logic                        o_is_new,
    input logic        [POS_IDX_W-1:0] o_pos_index,
    input logic signed [IDX_W-1:0]     o_tex_index,
    input logic signed [IDX_W-1:0]     o_norm_index
);

    // no result word straight out of reset
    `OCVD_ASSERT_ALWAYS(a_reset_quiet, !i_rst_n, !o_valid, "result word valid after reset")

    // skipped corner carries all-zero fields
    `OCVD_ASSERT_NOW(a_skip_zero, o_valid && (o_status == STATUS_SKIP),
        (o_vertex_number == '0) && !o_is_new && (o_pos_index == '0) &&
        (o_tex_index == '0) && (o_norm_index == '0), "skipped word has non-zero fields")

    // a new number only comes with an ok status, full never assigns
    `OCVD_ASSERT_NOW(a_new_ok, o_valid && o_is_new, o_status == STATUS_OK,
        "new vertex flagged on a non-ok word")

    `OCVD_ASSERT_NOW(a_full_zero, o_valid && (o_status == STATUS_FULL),
        (o_vertex_number == '0) && !o_is_new, "store-full word carries a number")

    // a stalled result word is held
    `OCVD_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_vertex_number),
        "stalled result word dropped or changed")

endmodule

bind obj_corner_vertex_dedup_unit ocvd_checker u_ocvd_checker (.*);

// ----- test/obj_corner_vertex_dedup_unit_tb.sv -----
// self-checking testbench for obj_corner_vertex_dedup_unit: random and directed corner words
// checked against an in-bench reference of reference resolution and exact-match vertex numbering
// depends on ocvd_pkg and the rtl top level only
module obj_corner_vertex_dedup_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ocvd_pkg::*;

    // store depth of the instance under test, kept at the rtl default
    localparam int STORE_DEPTH = DEF_MAX_VERTICES;
    // random words split over the three idling phases
    localparam int RANDOM_WORDS = 1800;
    // quiet cycles after the last result, well past the lookup latency
    localparam int DRAIN_CYCLES = 40;
    // clearing sweep, probing and all idling phases, taken many times over
    localparam longint unsigned CYCLE_LIMIT = 64'd10_000_000;
    // bound on the list of keys kept for replay
    localparam int KEY_POOL = 1024;

    // one input word as driven onto the ports
    typedef struct packed {
        logic signed [REF_W-1:0] pos_ref;
        logic signed [REF_W-1:0] tex_ref;
        logic signed [REF_W-1:0] norm_ref;
        logic [CNT_W-1:0]        pos_count;
        logic [CNT_W-1:0]        tex_count;
        logic [CNT_W-1:0]        norm_count;
    } t_corner;

    // one result word
    typedef struct packed {
        t_status                 status;
        logic [VNUM_W-1:0]       vertex_number;
        logic                    is_new;
        logic [POS_IDX_W-1:0]    pos_index;
        logic signed [IDX_W-1:0] tex_index;
        logic signed [IDX_W-1:0] norm_index;
    } t_result;

    // resolved triple, -1 meaning absent or out of range
    typedef struct {
        int p;
        int t;
        int n;
    } t_key;

    // vertex numbering predictor plus the queue of results still owed by the block
    class vertex_scoreboard;
        t_result awaited[$];
        int      number_of[bit [KEY_W-1:0]];
        int      allocated;
        int      depth;
        int      mismatches;
        int      fresh;
        int      repeats;
        int      skipped;
        int      refused;

        function new(int store_depth);
            depth = store_depth;
        endfunction

        // list size as the block sees it: capped so an index fits 16 bits
        static function int capped_size(logic [CNT_W-1:0] c);
            return (int'(c) > ATTR_LIMIT) ? ATTR_LIMIT : int'(c);
        endfunction

        // obj-style reference: positive is 1-based, negative counts from the end
        static function int resolve(logic signed [REF_W-1:0] r, logic [CNT_W-1:0] c);
            int sz;
            int idx;
            sz = capped_size(c);
            if (r > 0) begin
                idx = int'(r) - 1;
            end else if (r < 0) begin
                idx = sz + int'(r);
            end else begin
                return -1;
            end
            if (idx < 0 || idx >= sz) begin
                return -1;
            end
            return idx;
        endfunction

        function string describe(t_result r);
            return $sformatf("status %0d vertex %0d new %0b pos %0d tex %0d norm %0d",
                             r.status, r.vertex_number, r.is_new, r.pos_index,
                             $signed(r.tex_index), $signed(r.norm_index));
        endfunction

        // work out the result of an accepted word and update the numbering state
        function void note_corner(t_corner c);
            t_result         e;
            int              p;
            int              t;
            int              n;
            int              vnum;
            bit [KEY_W-1:0]  key;
            p = resolve(c.pos_ref, c.pos_count);
            t = resolve(c.tex_ref, c.tex_count);
            n = resolve(c.norm_ref, c.norm_count);
            e.vertex_number = '0;
            e.is_new        = 1'b0;
            e.pos_index     = '0;
            e.tex_index     = '0;
            e.norm_index    = '0;
            if (p < 0) begin
                e.status = STATUS_SKIP;
                skipped++;
            end else begin
                e.pos_index  = p[POS_IDX_W-1:0];
                e.tex_index  = t[IDX_W-1:0];
                e.norm_index = n[IDX_W-1:0];
                key = {p[IDX_W-1:0], t[IDX_W-1:0], n[IDX_W-1:0]};
                if (number_of.exists(key)) begin
                    vnum            = number_of[key];
                    e.status        = STATUS_OK;
                    e.vertex_number = vnum[VNUM_W-1:0];
                    repeats++;
                end else if (allocated >= depth) begin
                    e.status = STATUS_FULL;
                    refused++;
                end else begin
                    number_of[key]  = allocated;
                    e.status        = STATUS_OK;
                    e.vertex_number = allocated[VNUM_W-1:0];
                    e.is_new        = 1'b1;
                    allocated++;
                    fresh++;
                end
            end
            awaited.insert(awaited.size(), e);
        endfunction

        // compare a result word with the oldest outstanding one
        function void check_result(t_result got);
            t_result e;
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result word: %s", describe(got));
                end
                return;
            end
            e = awaited.pop_front();
            if (got.status !== e.status || got.vertex_number !== e.vertex_number ||
                got.is_new !== e.is_new || got.pos_index !== e.pos_index ||
                got.tex_index !== e.tex_index || got.norm_index !== e.norm_index) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result mismatch at %0t", $realtime);
                    $display("  wanted %s", describe(e));
                    $display("  got    %s", describe(got));
                end
            end
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    o_stall;
    logic signed [REF_W-1:0] i_pos_ref = '0;
    logic signed [REF_W-1:0] i_tex_ref = '0;
    logic signed [REF_W-1:0] i_norm_ref = '0;
    logic [CNT_W-1:0]        i_pos_count = '0;
    logic [CNT_W-1:0]        i_tex_count = '0;
    logic [CNT_W-1:0]        i_norm_count = '0;
    logic                    o_valid;
    logic                    i_stall = 1'b0;
    logic [1:0]              o_status;
    logic [VNUM_W-1:0]       o_vertex_number;
    logic                    o_is_new;
    logic [POS_IDX_W-1:0]    o_pos_index;
    logic signed [IDX_W-1:0] o_tex_index;
    logic signed [IDX_W-1:0] o_norm_index;

    vertex_scoreboard board;
    t_key             known_keys[$];
    int               tx_idle_pct = 6;
    int               rx_idle_pct = 86;
    longint unsigned  cycle_count = 0;

    obj_corner_vertex_dedup_unit #(
        .MAX_VERTICES(STORE_DEPTH)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_pos_ref      (i_pos_ref),
        .i_tex_ref      (i_tex_ref),
        .i_norm_ref     (i_norm_ref),
        .i_pos_count    (i_pos_count),
        .i_tex_count    (i_tex_count),
        .i_norm_count   (i_norm_count),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_vertex_number(o_vertex_number),
        .o_is_new       (o_is_new),
        .o_pos_index    (o_pos_index),
        .o_tex_index    (o_tex_index),
        .o_norm_index   (o_norm_index)
    );

    // 10 ns clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // raw reference that resolves to idx in a list of sz entries; for idx -1 an absent
    // or out-of-range reference, either side of the list, up to the ends of the field
    function automatic logic signed [REF_W-1:0] encode_ref(int idx, int sz);
        int pick;
        pick = $urandom_range(0, 3);
        if (idx >= 0) begin
            return pick[0] ? REF_W'(idx + 1) : REF_W'(idx - sz);
        end
        case (pick)
            0, 1: return '0;
            2: return REF_W'(sz + 1 + int'($urandom_range(0, 131070 - sz)));
            default: return REF_W'(-(sz + 1) - int'($urandom_range(0, 131071 - sz)));
        endcase
    endfunction

    // any count under which idx is still in range, often beyond the 16-bit cap
    function automatic logic [CNT_W-1:0] count_for(int idx);
        if (idx < 0) begin
            return CNT_W'($urandom_range(0, 131071));
        end
        return CNT_W'($urandom_range(idx + 1, 131071));
    endfunction

    function automatic t_corner make_corner(t_key k, logic [CNT_W-1:0] pc,
                                            logic [CNT_W-1:0] tc, logic [CNT_W-1:0] nc);
        t_corner c;
        c.pos_count  = pc;
        c.tex_count  = tc;
        c.norm_count = nc;
        c.pos_ref    = encode_ref(k.p, vertex_scoreboard::capped_size(pc));
        c.tex_ref    = encode_ref(k.t, vertex_scoreboard::capped_size(tc));
        c.norm_ref   = encode_ref(k.n, vertex_scoreboard::capped_size(nc));
        return c;
    endfunction

    // keep a bounded pool of triples for later replay
    function automatic void remember_key(t_key k);
        if (known_keys.size() < KEY_POOL) begin
            known_keys.insert(known_keys.size(), k);
        end else begin
            known_keys[$urandom_range(0, KEY_POOL - 1)] = k;
        end
    endfunction

    // mostly well-formed corners over small lists so repeats are common, some replays
    // of earlier triples through different raw references, broken positions and noise
    function automatic t_corner random_corner();
        t_corner c;
        t_key    k;
        int      mode;
        int      ps;
        int      ts;
        int      ns;
        mode = $urandom_range(0, 99);
        ps   = $urandom_range(1, 12);
        ts   = $urandom_range(0, 12);
        ns   = $urandom_range(0, 12);
        k.t  = (ts == 0 || $urandom_range(0, 7) == 0) ? -1 : int'($urandom_range(0, ts - 1));
        k.n  = (ns == 0 || $urandom_range(0, 7) == 0) ? -1 : int'($urandom_range(0, ns - 1));
        if (mode < 45) begin
            k.p = $urandom_range(0, ps - 1);
            c   = make_corner(k, CNT_W'(ps), CNT_W'(ts), CNT_W'(ns));
            remember_key(k);
        end else if (mode < 70 && known_keys.size() != 0) begin
            k = known_keys[$urandom_range(0, known_keys.size() - 1)];
            c = make_corner(k, count_for(k.p), count_for(k.t), count_for(k.n));
        end else if (mode < 85) begin
            // position absent or outside its list
            k.p = -1;
            c   = make_corner(k, CNT_W'($urandom_range(0, 12)), CNT_W'(ts), CNT_W'(ns));
        end else begin
            c.pos_ref    = REF_W'($urandom);
            c.tex_ref    = REF_W'($urandom);
            c.norm_ref   = REF_W'($urandom);
            c.pos_count  = CNT_W'($urandom);
            c.tex_count  = CNT_W'($urandom);
            c.norm_count = CNT_W'($urandom);
        end
        return c;
    endfunction

    // wide random triple, nearly always a fresh vertex
    function automatic t_corner fill_corner();
        t_key k;
        k.p = $urandom_range(0, 65535);
        k.t = int'($urandom_range(0, 65536)) - 1;
        k.n = int'($urandom_range(0, 65536)) - 1;
        remember_key(k);
        return make_corner(k, count_for(k.p), count_for(k.t), count_for(k.n));
    endfunction

    // present one word, holding it until the block takes it; valid is left high so the
    // next word can follow straight on
    task automatic send_corner(input t_corner c);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_pos_ref    <= c.pos_ref;
        i_tex_ref    <= c.tex_ref;
        i_norm_ref   <= c.norm_ref;
        i_pos_count  <= c.pos_count;
        i_tex_count  <= c.tex_count;
        i_norm_count <= c.norm_count;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        board.note_corner(c);
    endtask

    task automatic send_refs(input logic signed [REF_W-1:0] pr, input logic signed [REF_W-1:0] tr,
                             input logic signed [REF_W-1:0] nr, input logic [CNT_W-1:0] pc,
                             input logic [CNT_W-1:0] tc, input logic [CNT_W-1:0] nc);
        t_corner c;
        c.pos_ref    = pr;
        c.tex_ref    = tr;
        c.norm_ref   = nr;
        c.pos_count  = pc;
        c.tex_count  = tc;
        c.norm_count = nc;
        send_corner(c);
    endtask

    // drop valid and hold off until every outstanding result word has come back
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (board.awaited.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // receiver back-pressure, rate set by the current phase
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end

    // result monitor: a word moves when valid is high and stall is low at the edge
    always @(posedge i_clk) begin : result_monitor
        t_result got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.status        = t_status'(o_status);
            got.vertex_number = o_vertex_number;
            got.is_new        = o_is_new;
            got.pos_index     = o_pos_index;
            got.tex_index     = o_tex_index;
            got.norm_index    = o_norm_index;
            board.check_result(got);
        end
    end

    // watchdog, also the cycle count for the summary
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d result words outstanding",
                 cycle_count, board.awaited.size());
        $display("** obj_corner_vertex_dedup_unit: FAILED **");
        $finish;
    end

    initial begin
        board = new(STORE_DEPTH);

        // reset held low first; the block then clears its table with stall high
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed words, under the slow receiver
        send_refs(1, 1, 1, 8, 8, 8);                      // first vertex
        send_refs(1, 1, 1, 8, 8, 8);                      // same word again
        send_refs(-8, -8, -8, 8, 8, 8);                   // same triple from the end of the lists
        send_refs(0, 1, 1, 8, 8, 8);                      // position absent
        send_refs(9, 1, 1, 8, 8, 8);                      // position one past the end
        send_refs(-9, 1, 1, 8, 8, 8);                     // position one before the start
        send_refs(1, 1, 1, 0, 8, 8);                      // empty position list
        send_refs(2, 0, 0, 8, 8, 8);                      // texture and normal absent
        send_refs(2, 9, -9, 8, 8, 8);                     // out of range behaves as absent
        send_refs(2, -9, 9, 8, 0, 0);                     // empty lists behave as absent
        send_refs(131071, 1, 1, 17'h1FFFF, 8, 8);         // largest reference, count capped
        send_refs(65536, 65536, 65536, 17'h1FFFF, 65536, 65537);  // last index of each list
        send_refs(-1, -1, -1, 65536, 65536, 65536);       // same last indices from the end
        send_refs(-65536, -131072, 131071, 65536, 17'h1FFFF, 17'h1FFFF);
        send_refs(-131072, 1, 1, 17'h1FFFF, 8, 8);        // most negative position reference
        send_refs(1, -65536, 65536, 65536, 65536, 65535); // normal one past the end of its list
        send_refs(3, 2, 1, 3, 3, 1);
        send_refs(-1, -2, -1, 3, 3, 1);                   // same triple, negative form
        send_refs(3, 3, 2, 3, 2, 2);                      // texture one past the end, normal its last entry

        // slow receiver, sender mostly busy
        repeat (RANDOM_WORDS / 3) send_corner(random_corner());

        // let the pipe empty completely before the next phase
        wait_drained();

        // slow sender, receiver mostly ready
        tx_idle_pct = 86;
        rx_idle_pct = 6;
        repeat (RANDOM_WORDS / 3) send_corner(random_corner());

        // no idling: wide triples that mostly take fresh numbers, mixed with ordinary words
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        repeat (RANDOM_WORDS / 3) begin
            if ($urandom_range(0, 1) == 0) begin
                send_corner(fill_corner());
            end else begin
                send_corner(random_corner());
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d corner words in %0d cycles: %0d new vertices, %0d repeats, %0d skipped,",
                 board.fresh + board.repeats + board.skipped + board.refused, cycle_count,
                 board.fresh, board.repeats, board.skipped);
        $display("  %0d refused with the store full; %0d of %0d vertex numbers used, %0d mismatches",
                 board.refused, board.allocated, STORE_DEPTH, board.mismatches);
        if (board.mismatches == 0 && board.awaited.size() == 0) begin
            $display("** obj_corner_vertex_dedup_unit: PASSED **");
        end else begin
            $display("** obj_corner_vertex_dedup_unit: FAILED **");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/ocvd_pkg.sv
rtl/core/ocvd_resolve.sv
rtl/core/ocvd_table.sv
rtl/core/obj_corner_vertex_dedup_unit.sv
rtl/core/ocvd_checker.sv
test/obj_corner_vertex_dedup_unit_tb.sv
